// ===== sv/phcq_pkg.sv =====
// Shared types, codes and constants of the piezo hit capture qualifier.
`timescale 1ns / 1ps
package phcq_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int OUT_DEPTH       = 4;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_SIM_HIT     = 3'd1,
    OP_HOST_RESET  = 3'd2,
    OP_PREP_UPD    = 3'd3,
    OP_RECOVER_UPD = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_UNCONF = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_CAPT   = 2'd2,
    MODE_UPD    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_RESET    = 3'd1,
    EV_CAPTURED = 3'd2,
    EV_LOCKED   = 3'd3,
    EV_UPDFAIL  = 3'd4
  } ev_kind_t;

  typedef enum logic [2:0] {
    SRC_SENSOR = 3'd0,
    SRC_SIM    = 3'd1,
    SRC_HOST   = 3'd2,
    SRC_AUTO   = 3'd3,
    SRC_NONE   = 3'd4
  } ev_cause_t;

  typedef enum logic [2:0] {
    REG_CONFIGURED    = 3'd0,
    REG_LOCK_AFTER    = 3'd1,
    REG_AUTO_RESET    = 3'd2,
    REG_HIT_COOLDOWN  = 3'd3,
    REG_SAMPLE_IVL    = 3'd4,
    REG_HIT_THRESH    = 3'd5,
    REG_RELEASE_THRESH = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic        configured;
    logic        lock_after_hit;
    logic [31:0] auto_reset_ms;
    logic [31:0] hit_cooldown_ms;
    logic [31:0] sample_interval_ms;
  } cfg_t;

  // Write of the configured register, which also moves the mode.
  typedef struct packed {
    logic wr;
    logic value;
  } cfg_ctl_t;

  // One result beat without its peak field.
  typedef struct packed {
    ev_kind_t    kind;
    ev_cause_t   cause;
    mode_t       mode;
    logic        captured;
    logic [31:0] cap_cnt;
    logic [31:0] ign_cnt;
    logic        accepted;
    logic        last;
  } res_stat_t;

  localparam int STAT_BITS = $bits(res_stat_t);

endpackage

// ===== sv/phcq_in_if.sv =====
// Input channel carrying one event beat.
`timescale 1ns / 1ps
interface phcq_in_if
  import phcq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             opcode;
  logic [31:0]            now_ms;
  logic [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, opcode, now_ms, sample_value, input ready);
  modport sink (input valid, opcode, now_ms, sample_value, output ready);
endinterface

// ===== sv/phcq_out_if.sv =====
// Output channel carrying one result beat.
`timescale 1ns / 1ps
interface phcq_out_if
  import phcq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             event_kind;
  logic [2:0]             event_cause;
  logic [SAMPLE_BITS-1:0] event_peak;
  logic [1:0]             mode;
  logic                   is_captured;
  logic [31:0]            capture_count;
  logic [31:0]            ignored_count;
  logic                   update_safe;
  logic                   hit_accepted;
  logic                   last_result;

  modport source (output valid, event_kind, event_cause, event_peak, mode, is_captured,
                  capture_count, ignored_count, update_safe, hit_accepted, last_result,
                  input ready);
  modport sink (input valid, event_kind, event_cause, event_peak, mode, is_captured,
                capture_count, ignored_count, update_safe, hit_accepted, last_result,
                output ready);
endinterface

// ===== sv/phcq_cfg_regs.sv =====
// Configuration register file with its write decoder.
`timescale 1ns / 1ps
module phcq_cfg_regs
  import phcq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg,
  output cfg_ctl_t                  cfg_ctl,
  output logic [SAMPLE_BITS-1:0]    hit_threshold,
  output logic [SAMPLE_BITS-1:0]    release_threshold
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.configured         <= 1'b0;
      cfg.lock_after_hit     <= 1'b1;
      cfg.auto_reset_ms      <= '0;
      cfg.hit_cooldown_ms    <= '0;
      cfg.sample_interval_ms <= '0;
      hit_threshold          <= '1;
      release_threshold      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CONFIGURED:     cfg.configured         <= cfg_data[0];
        REG_LOCK_AFTER:     cfg.lock_after_hit     <= cfg_data[0];
        REG_AUTO_RESET:     cfg.auto_reset_ms      <= cfg_data[31:0];
        REG_HIT_COOLDOWN:   cfg.hit_cooldown_ms    <= cfg_data[31:0];
        REG_SAMPLE_IVL:     cfg.sample_interval_ms <= cfg_data[31:0];
        REG_HIT_THRESH:     hit_threshold          <= cfg_data[SAMPLE_BITS-1:0];
        REG_RELEASE_THRESH: release_threshold      <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The core moves the mode on the same edge as the configured bit changes, unless it evaluates an event on that edge.
  assign cfg_ctl.wr    = cfg_we && (cfg_reg_t'(cfg_index) == REG_CONFIGURED);
  assign cfg_ctl.value = cfg_data[0];

endmodule

// ===== sv/phcq_core.sv =====
// Station state and the combinational evaluation of one event.
`timescale 1ns / 1ps
module phcq_core
  import phcq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  cfg_ctl_t               cfg_ctl,
  input  logic [SAMPLE_BITS-1:0] hit_threshold,
  input  logic [SAMPLE_BITS-1:0] release_threshold,
  input  logic                   step,
  input  logic [2:0]             opcode,
  input  logic [31:0]            now_ms,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  output res_stat_t              res0,
  output logic [SAMPLE_BITS-1:0] res0_peak,
  output res_stat_t              res1,
  output logic [SAMPLE_BITS-1:0] res1_peak,
  output logic                   two_results
);

  mode_t       mode_q, mode_next;
  logic        captured_q, captured_next;
  logic        armed_q, armed_next;
  logic [31:0] last_sample_q, last_sample_next;
  logic [31:0] last_hit_q, last_hit_next;
  logic        hit_rec_q, hit_rec_next;
  logic [31:0] cap_time_q, cap_time_next;
  logic [31:0] cap_tot_q, cap_tot_next;
  logic [31:0] ign_tot_q, ign_tot_next;

  logic [31:0] since_sample, since_hit;

  assign since_sample = now_ms - last_sample_q;
  assign since_hit    = now_ms - last_hit_q;

  function automatic res_stat_t mk_stat(ev_kind_t k, ev_cause_t c, mode_t m, logic cp,
                                        logic [31:0] ct, logic [31:0] it);
    res_stat_t s;
    s.kind     = k;
    s.cause    = c;
    s.mode     = m;
    s.captured = cp;
    s.cap_cnt  = ct;
    s.ign_cnt  = it;
    s.accepted = 1'b0;
    s.last     = 1'b0;
    return s;
  endfunction

  always_comb begin
    logic        cap_try;
    ev_cause_t   cap_cause;
    logic        do_rst;
    logic        accepted;
    logic [1:0]  n_res;
    logic [31:0] since_cap;

    mode_next        = mode_q;
    captured_next    = captured_q;
    armed_next       = armed_q;
    last_sample_next = last_sample_q;
    last_hit_next    = last_hit_q;
    hit_rec_next     = hit_rec_q;
    cap_time_next    = cap_time_q;
    cap_tot_next     = cap_tot_q;
    ign_tot_next     = ign_tot_q;
    cap_try          = 1'b0;
    cap_cause        = SRC_SENSOR;
    accepted         = 1'b0;
    n_res            = 2'd0;
    res0             = mk_stat(EV_NONE, SRC_NONE, mode_q, captured_q, cap_tot_q, ign_tot_q);
    res0_peak        = '0;
    res1             = res0;
    res1_peak        = '0;

    // Sensor sampling with hysteresis.
    if (opcode_t'(opcode) == OP_TICK && mode_q != MODE_UPD && cfg.configured &&
        (cfg.sample_interval_ms == 32'd0 || since_sample >= cfg.sample_interval_ms)) begin
      last_sample_next = now_ms;
      if (!armed_q) begin
        if (sample_value <= release_threshold) armed_next = 1'b1;
      end else if (sample_value >= hit_threshold) begin
        armed_next = 1'b0;
        cap_try    = 1'b1;
      end
    end
    if (opcode_t'(opcode) == OP_SIM_HIT) begin
      cap_try   = 1'b1;
      cap_cause = SRC_SIM;
    end

    // The lock check wins over every other capture condition.
    if (cap_try) begin
      if (captured_q && cfg.lock_after_hit) begin
        ign_tot_next = ign_tot_q + 32'd1;
        res0      = mk_stat(EV_LOCKED, cap_cause, mode_next, captured_next, cap_tot_next,
                            ign_tot_next);
        res0_peak = sample_value;
        n_res     = 2'd1;
      end else if (cfg.configured && mode_q != MODE_UPD &&
                   !(hit_rec_q && since_hit < cfg.hit_cooldown_ms)) begin
        captured_next = 1'b1;
        mode_next     = MODE_CAPT;
        cap_tot_next  = cap_tot_q + 32'd1;
        last_hit_next = now_ms;
        hit_rec_next  = 1'b1;
        cap_time_next = now_ms;
        accepted      = 1'b1;
        res0      = mk_stat(EV_CAPTURED, cap_cause, mode_next, captured_next, cap_tot_next,
                            ign_tot_next);
        res0_peak = sample_value;
        n_res     = 2'd1;
      end
    end

    since_cap = now_ms - cap_time_next;
    do_rst = (opcode_t'(opcode) == OP_HOST_RESET) ||
             (opcode_t'(opcode) == OP_TICK && captured_next && cfg.auto_reset_ms != 32'd0 &&
              since_cap >= cfg.auto_reset_ms);

    if (do_rst) begin
      captured_next = 1'b0;
      ign_tot_next  = '0;
      mode_next     = cfg.configured ? MODE_WAIT : MODE_UNCONF;
      armed_next    = 1'b1;
      last_hit_next = '0;
      hit_rec_next  = 1'b0;
      cap_time_next = '0;
      if (n_res == 2'd0) begin
        res0 = mk_stat(EV_RESET, (opcode_t'(opcode) == OP_HOST_RESET) ? SRC_HOST : SRC_AUTO,
                       mode_next, captured_next, cap_tot_next, ign_tot_next);
        n_res = 2'd1;
      end else begin
        res1 = mk_stat(EV_RESET, SRC_AUTO, mode_next, captured_next, cap_tot_next,
                       ign_tot_next);
        n_res = 2'd2;
      end
    end

    case (opcode_t'(opcode))
      OP_PREP_UPD: mode_next = MODE_UPD;
      OP_RECOVER_UPD: begin
        mode_next = !cfg.configured ? MODE_UNCONF : (captured_q ? MODE_CAPT : MODE_WAIT);
        res0  = mk_stat(EV_UPDFAIL, SRC_HOST, mode_next, captured_next, cap_tot_next,
                        ign_tot_next);
        n_res = 2'd1;
      end
      default: ;
    endcase

    // An item with no event still reports the status once.
    if (n_res == 2'd0) begin
      res0 = mk_stat(EV_NONE, SRC_NONE, mode_next, captured_next, cap_tot_next, ign_tot_next);
    end

    two_results   = (n_res == 2'd2);
    res0.accepted = accepted;
    res1.accepted = accepted;
    res0.last     = !two_results;
    res1.last     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q        <= MODE_UNCONF;
      captured_q    <= 1'b0;
      armed_q       <= 1'b1;
      last_sample_q <= '0;
      last_hit_q    <= '0;
      hit_rec_q     <= 1'b0;
      cap_time_q    <= '0;
      cap_tot_q     <= '0;
      ign_tot_q     <= '0;
    end else if (step) begin
      mode_q        <= mode_next;
      captured_q    <= captured_next;
      armed_q       <= armed_next;
      last_sample_q <= last_sample_next;
      last_hit_q    <= last_hit_next;
      hit_rec_q     <= hit_rec_next;
      cap_time_q    <= cap_time_next;
      cap_tot_q     <= cap_tot_next;
      ign_tot_q     <= ign_tot_next;
    end else if (cfg_ctl.wr) begin
      if (!cfg_ctl.value) begin
        mode_q <= MODE_UNCONF;
      end else if (mode_q == MODE_UNCONF) begin
        mode_q <= captured_q ? MODE_CAPT : MODE_WAIT;
      end
    end
  end

endmodule

// ===== sv/phcq_out_fifo.sv =====
// Result queue that takes one or two beats per cycle and releases one per cycle while it is popped.
`timescale 1ns / 1ps
module phcq_out_fifo
  import phcq_pkg::*;
#(
  parameter int WIDTH = STAT_BITS + SAMPLE_BITS_DEF,
  parameter int DEPTH = OUT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       push_two,
  input  logic [WIDTH-1:0]           din0,
  input  logic [WIDTH-1:0]           din1,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       dout_valid,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr, wr_ptr1, wr_ptr2, rd_ptr1;
  logic [LW-1:0]    level_next;
  logic             do_pop;

  function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr1    = inc(wr_ptr);
  assign wr_ptr2    = inc(wr_ptr1);
  assign rd_ptr1    = inc(rd_ptr);
  assign do_pop     = pop && dout_valid;
  assign dout_valid = (level != '0);
  assign dout       = mem[rd_ptr];

  always_comb begin
    level_next = level;
    if (push) level_next = level_next + (push_two ? LW'(2) : LW'(1));
    if (do_pop) level_next = level_next - LW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din0;
      if (push_two) mem[wr_ptr1] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= push_two ? wr_ptr2 : wr_ptr1;
      if (do_pop) rd_ptr <= rd_ptr1;
      level <= level_next;
    end
  end

endmodule

// ===== sv/piezo_hit_capture_qualifier.sv =====
// Piezo hit capture qualifier: input register, evaluation core and result queue.
//
// Usage: event beats (opcode, now_ms, sample_value) arrive on the items channel
// and are accepted when valid and ready are both high. Each beat yields one or
// two result beats on the results channel, in order; last_result marks the
// final beat of an event. Registers are written through cfg_we, cfg_index and
// cfg_data while the block is idle; writes to unused indexes are dropped.
// An accepted beat is evaluated while it sits in the input register, and its
// results enter the queue at the edge on which the beat leaves that register;
// its first result beat is then offered from the queue. Throughput is one
// event per cycle while the receiver keeps ready high, limited by the
// one-beat-per-cycle result channel when events give two results.
// The four-entry result queue sets the stall behavior: an event leaves the
// input register only when two entries are free, so a receiver that holds
// ready low fills the queue and then the input register, after which items
// ready falls. Nothing is dropped. The synchronous reset empties the queue,
// clears the input register and returns all registers and station state to
// their reset values.
`timescale 1ns / 1ps
module piezo_hit_capture_qualifier
  import phcq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  phcq_in_if.sink                   items,
  phcq_out_if.source                results
);

  localparam int EW = STAT_BITS + SAMPLE_BITS;
  localparam int LW = $clog2(OUT_DEPTH + 1);

  cfg_t                   cfg;
  cfg_ctl_t               cfg_ctl;
  logic [SAMPLE_BITS-1:0] hit_threshold, release_threshold;

  logic                   in_valid;
  logic [2:0]             in_opcode;
  logic [31:0]            in_now;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   fire;

  res_stat_t              res0, res1, res_out;
  logic [SAMPLE_BITS-1:0] res0_peak, res1_peak, peak_out;
  logic                   two_results;
  logic [EW-1:0]          q_dout;
  logic [LW-1:0]          q_level;

  phcq_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cfg               (cfg),
    .cfg_ctl           (cfg_ctl),
    .hit_threshold     (hit_threshold),
    .release_threshold (release_threshold)
  );

  // The held beat moves on when the queue has room for two results.
  assign fire        = in_valid && (q_level <= LW'(OUT_DEPTH - 2));
  assign items.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      in_opcode <= items.opcode;
      in_now    <= items.now_ms;
      in_sample <= items.sample_value;
    end
  end

  phcq_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cfg_ctl           (cfg_ctl),
    .hit_threshold     (hit_threshold),
    .release_threshold (release_threshold),
    .step              (fire),
    .opcode            (in_opcode),
    .now_ms            (in_now),
    .sample_value      (in_sample),
    .res0              (res0),
    .res0_peak         (res0_peak),
    .res1              (res1),
    .res1_peak         (res1_peak),
    .two_results       (two_results)
  );

  phcq_out_fifo #(.WIDTH(EW), .DEPTH(OUT_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .push_two   (two_results),
    .din0       ({res0, res0_peak}),
    .din1       ({res1, res1_peak}),
    .pop        (results.ready),
    .dout       (q_dout),
    .dout_valid (results.valid),
    .level      (q_level)
  );

  assign res_out  = res_stat_t'(q_dout[EW-1:SAMPLE_BITS]);
  assign peak_out = q_dout[SAMPLE_BITS-1:0];

  assign results.event_kind    = res_out.kind;
  assign results.event_cause   = res_out.cause;
  assign results.event_peak    = peak_out;
  assign results.mode          = res_out.mode;
  assign results.is_captured   = res_out.captured;
  assign results.capture_count = res_out.cap_cnt;
  assign results.ignored_count = res_out.ign_cnt;
  assign results.update_safe   = 1'b1;
  assign results.hit_accepted  = res_out.accepted;
  assign results.last_result   = res_out.last;

  // A capture can never be followed by an automatic reset in the same event.
  a_accept_is_capture: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.hit_accepted |->
      results.event_kind == EV_CAPTURED && results.last_result)
    else $error("accepted hit on a result that is not a final capture");

  // The second beat of a pair must already sit in the queue.
  a_pair_queued: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.last_result |-> q_level >= LW'(2))
    else $error("first beat of a pair without its partner queued");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.event_kind == EV_RESET |->
      !results.is_captured && results.ignored_count == 32'd0)
    else $error("reset result still shows a capture or ignored hits");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    q_level <= LW'(OUT_DEPTH))
    else $error("result queue overfilled");

endmodule

// ===== verif/phcq_result_checker.sv =====
// Scoreboard for the piezo hit capture qualifier: mirrors its state and checks result beats.
`timescale 1ns / 1ps
module phcq_result_checker
  import phcq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  phcq_in_if                        items,
  phcq_out_if                       results,
  output int                        mismatches,
  output int                        outstanding,
  output int                        beats_checked
);

  localparam int MAX_REPORTS = 10;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    ev_kind_t    kind;
    ev_cause_t   cause;
    sample_t     peak;
    mode_t       mode;
    logic        captured;
    logic [31:0] cap_cnt;
    logic [31:0] ign_cnt;
    logic        upd_safe;
    logic        accepted;
    logic        last;
  } beat_t;

  // Register mirror.
  logic        cfg_configured;
  logic        cfg_lock;
  logic [31:0] cfg_auto_reset;
  logic [31:0] cfg_cooldown;
  logic [31:0] cfg_interval;
  sample_t     cfg_hit_level;
  sample_t     cfg_release_level;

  // Station state mirror.
  mode_t       st_mode;
  logic        st_captured;
  logic        st_armed;
  logic        st_hit_seen;
  logic [31:0] st_last_sample;
  logic [31:0] st_last_hit;
  logic [31:0] st_capture_time;
  logic [31:0] st_captures;
  logic [31:0] st_ignored;

  logic  hit_taken;
  beat_t event_beats[$];
  beat_t expected_beats[$];
  int    fault_count;
  int    checked_count;

  function automatic void emit(ev_kind_t kind, ev_cause_t cause, sample_t peak);
    beat_t b;
    b.kind     = kind;
    b.cause    = cause;
    b.peak     = peak;
    b.mode     = st_mode;
    b.captured = st_captured;
    b.cap_cnt  = st_captures;
    b.ign_cnt  = st_ignored;
    b.upd_safe = 1'b1;
    b.accepted = 1'b0;
    b.last     = 1'b0;
    event_beats.push_back(b);
  endfunction

  function automatic void clear_capture(ev_cause_t cause);
    st_captured     = 1'b0;
    st_ignored      = '0;
    st_mode         = cfg_configured ? MODE_WAIT : MODE_UNCONF;
    st_armed        = 1'b1;
    st_last_hit     = '0;
    st_hit_seen     = 1'b0;
    st_capture_time = '0;
    emit(EV_RESET, cause, '0);
  endfunction

  function automatic void attempt_capture(ev_cause_t cause, sample_t peak, logic [31:0] now);
    // A locked station counts the hit before any other check is made.
    if (st_captured && cfg_lock) begin
      st_ignored = st_ignored + 32'd1;
      emit(EV_LOCKED, cause, peak);
    end else if (cfg_configured && st_mode != MODE_UPD &&
                 !(st_hit_seen && (now - st_last_hit) < cfg_cooldown)) begin
      st_captured     = 1'b1;
      st_mode         = MODE_CAPT;
      st_captures     = st_captures + 32'd1;
      st_last_hit     = now;
      st_hit_seen     = 1'b1;
      st_capture_time = now;
      hit_taken       = 1'b1;
      emit(EV_CAPTURED, cause, peak);
    end
  endfunction

  function automatic void take_sample(sample_t value, logic [31:0] now);
    if (cfg_configured &&
        (cfg_interval == '0 || (now - st_last_sample) >= cfg_interval)) begin
      st_last_sample = now;
      if (!st_armed) begin
        if (value <= cfg_release_level) st_armed = 1'b1;
      end else if (value >= cfg_hit_level) begin
        st_armed = 1'b0;
        attempt_capture(SRC_SENSOR, value, now);
      end
    end
  endfunction

  function automatic void predict_event(logic [2:0] op, logic [31:0] now, sample_t value);
    beat_t b;
    event_beats.delete();
    hit_taken = 1'b0;
    case (op)
      OP_TICK: begin
        if (st_mode != MODE_UPD) take_sample(value, now);
        if (st_captured && cfg_auto_reset != '0 && (now - st_capture_time) >= cfg_auto_reset)
          clear_capture(SRC_AUTO);
      end
      OP_SIM_HIT: attempt_capture(SRC_SIM, value, now);
      OP_HOST_RESET: clear_capture(SRC_HOST);
      OP_PREP_UPD: st_mode = MODE_UPD;
      OP_RECOVER_UPD: begin
        if (!cfg_configured) st_mode = MODE_UNCONF;
        else if (st_captured) st_mode = MODE_CAPT;
        else st_mode = MODE_WAIT;
        emit(EV_UPDFAIL, SRC_HOST, '0);
      end
      default: ;
    endcase
    if (event_beats.size() == 0) emit(EV_NONE, SRC_NONE, '0);
    while (event_beats.size() > 0) begin
      b          = event_beats.pop_front();
      b.accepted = hit_taken;
      b.last     = (event_beats.size() == 0);
      expected_beats.push_back(b);
    end
  endfunction

  function automatic void write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
    case (idx)
      REG_CONFIGURED: begin
        cfg_configured = data[0];
        if (!data[0]) st_mode = MODE_UNCONF;
        else if (st_mode == MODE_UNCONF) st_mode = st_captured ? MODE_CAPT : MODE_WAIT;
      end
      REG_LOCK_AFTER: cfg_lock = data[0];
      REG_AUTO_RESET: cfg_auto_reset = data;
      REG_HIT_COOLDOWN: cfg_cooldown = data;
      REG_SAMPLE_IVL: cfg_interval = data;
      REG_HIT_THRESH: cfg_hit_level = data[SAMPLE_BITS-1:0];
      REG_RELEASE_THRESH: cfg_release_level = data[SAMPLE_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic string beat_text(beat_t b);
    return $sformatf("kind=%0d cause=%0d peak=%h mode=%0d capt=%b caps=%0d ign=%0d safe=%b acc=%b last=%b",
                     b.kind, b.cause, b.peak, b.mode, b.captured, b.cap_cnt, b.ign_cnt,
                     b.upd_safe, b.accepted, b.last);
  endfunction

  function automatic void check_beat(beat_t got);
    beat_t want;
    checked_count++;
    if (expected_beats.size() == 0) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("%0t: result beat with nothing expected: %s", $realtime, beat_text(got));
    end else begin
      want = expected_beats.pop_front();
      if (got !== want) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %s", beat_text(want));
          $display("  actual   %s", beat_text(got));
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    beat_t got;
    if (rst) begin
      cfg_configured    = 1'b0;
      cfg_lock          = 1'b1;
      cfg_auto_reset    = '0;
      cfg_cooldown      = '0;
      cfg_interval      = '0;
      cfg_hit_level     = '1;
      cfg_release_level = '0;
      st_mode           = MODE_UNCONF;
      st_captured       = 1'b0;
      st_armed          = 1'b1;
      st_hit_seen       = 1'b0;
      st_last_sample    = '0;
      st_last_hit       = '0;
      st_capture_time   = '0;
      st_captures       = '0;
      st_ignored        = '0;
      expected_beats.delete();
      fault_count       = 0;
      checked_count     = 0;
    end else begin
      // The beat leaving now was produced before anything accepted at this edge.
      if (results.valid && results.ready) begin
        got.kind     = ev_kind_t'(results.event_kind);
        got.cause    = ev_cause_t'(results.event_cause);
        got.peak     = results.event_peak;
        got.mode     = mode_t'(results.mode);
        got.captured = results.is_captured;
        got.cap_cnt  = results.capture_count;
        got.ign_cnt  = results.ignored_count;
        got.upd_safe = results.update_safe;
        got.accepted = results.hit_accepted;
        got.last     = results.last_result;
        check_beat(got);
      end
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (items.valid && items.ready)
        predict_event(items.opcode, items.now_ms, items.sample_value);
    end
    mismatches    <= fault_count;
    outstanding   <= expected_beats.size();
    beats_checked <= checked_count;
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the piezo hit capture qualifier: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
  import phcq_pkg::*;

  localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
  localparam int RESET_CYCLES  = 9;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 80;
  localparam int SQUEEZE_BEATS = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int REG_COUNT     = 7;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_EVENTS  = 200;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int mismatches;
  int outstanding;
  int beats_checked;
  int events_sent;
  int settings_used;
  int hold_token;  // bumped by the sender to ask the receiver for a long hold-off
  logic no_idle;   // both sides run without gaps while set

  logic [31:0]            reg_image [REG_COUNT];
  logic [31:0]            clock_ms;
  logic [SAMPLE_BITS-1:0] level_hi;
  logic [SAMPLE_BITS-1:0] level_lo;

  phcq_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) items ();
  phcq_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) results ();

  piezo_hit_capture_qualifier #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .items    (items),
    .results  (results)
  );

  phcq_result_checker #(.SAMPLE_BITS(SAMPLE_BITS)) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .items        (items),
    .results      (results),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .beats_checked(beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_span(int typical);
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3: return '1;
      default: return $urandom_range(1, typical);
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_level(logic [SAMPLE_BITS-1:0] lo,
                                                        logic [SAMPLE_BITS-1:0] hi);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SAMPLE_MAX;
      default: return SAMPLE_BITS'($urandom_range(lo, hi));
    endcase
  endfunction

  // Mostly clear hits and clear releases, so the hysteresis cycles often.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_BITS'($urandom_range(level_hi, SAMPLE_MAX));
      4, 5, 6, 7: return SAMPLE_BITS'($urandom_range(0, level_lo));
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] next_time();
    case ($urandom_range(0, 19))
      0: clock_ms = $urandom();
      1: clock_ms = clock_ms + $urandom_range(200, 5000);
      default: clock_ms = clock_ms + $urandom_range(0, 25);
    endcase
    return clock_ms;
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return OP_TICK;
    if (r < 82) return OP_SIM_HIT;
    if (r < 88) return OP_HOST_RESET;
    if (r < 92) return OP_PREP_UPD;
    if (r < 97) return OP_RECOVER_UPD;
    return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
  endfunction

  task automatic send_event(logic [2:0] op, logic [31:0] now, logic [SAMPLE_BITS-1:0] value);
    items.valid        <= 1'b1;
    items.opcode       <= op;
    items.now_ms       <= now;
    items.sample_value <= value;
    do @(posedge clk); while (!items.ready);
    events_sent++;
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      items.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    items.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes every register from reg_image, then a write to the unused index.
  task automatic write_regs();
    int i;
    for (i = 0; i < REG_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_BITS'(i);
      cfg_data  <= reg_image[i];
      @(posedge clk);
    end
    cfg_index <= REG_SPARE;
    cfg_data  <= $urandom();
    @(posedge clk);
    cfg_we   <= 1'b0;
    level_hi = reg_image[REG_HIT_THRESH][SAMPLE_BITS-1:0];
    level_lo = reg_image[REG_RELEASE_THRESH][SAMPLE_BITS-1:0];
    settings_used++;
  endtask

  task automatic load_settings(logic conf, logic lock, logic [31:0] auto_ms,
                               logic [31:0] cool_ms, logic [31:0] ivl_ms,
                               logic [31:0] hit_data, logic [31:0] rel_data);
    reg_image[REG_CONFIGURED]     = {31'd0, conf};
    reg_image[REG_LOCK_AFTER]     = {31'd0, lock};
    reg_image[REG_AUTO_RESET]     = auto_ms;
    reg_image[REG_HIT_COOLDOWN]   = cool_ms;
    reg_image[REG_SAMPLE_IVL]     = ivl_ms;
    reg_image[REG_HIT_THRESH]     = hit_data;
    reg_image[REG_RELEASE_THRESH] = rel_data;
    write_regs();
  endtask

  task automatic pick_settings();
    logic [SAMPLE_BITS-1:0] hit_lvl;
    logic [SAMPLE_BITS-1:0] rel_lvl;
    hit_lvl = pick_level(SAMPLE_MAX / 2, SAMPLE_MAX);
    rel_lvl = pick_level(0, hit_lvl / 2);
    reg_image[REG_CONFIGURED]     = ($urandom_range(0, 9) != 0) ? 32'd1 : 32'd0;
    // Upper bits are junk on purpose; only the low bit or sample bits count.
    reg_image[REG_LOCK_AFTER]     = $urandom();
    reg_image[REG_AUTO_RESET]     = pick_span(300);
    reg_image[REG_HIT_COOLDOWN]   = pick_span(150);
    reg_image[REG_SAMPLE_IVL]     = pick_span(15);
    reg_image[REG_HIT_THRESH]     = ($urandom() << SAMPLE_BITS) | 32'(hit_lvl);
    reg_image[REG_RELEASE_THRESH] = ($urandom() << SAMPLE_BITS) | 32'(rel_lvl);
  endtask

  task automatic random_phase(bit squeeze);
    int n;
    for (n = 0; n < PHASE_EVENTS; n++) begin
      if (squeeze && n == 0) hold_token <= hold_token + 1;
      send_event(pick_op(), next_time(), pick_sample());
      // Back-to-back beats while the receiver holds off fill the block up.
      if (!(squeeze && n < SQUEEZE_BEATS)) pause_sender(idle_gap());
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  initial begin : result_sink
    int run;
    int gap;
    int served;
    served = 0;
    results.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_token != served) begin
        served = hold_token;
        results.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      results.ready <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        results.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((items.valid && items.ready) || (results.valid && results.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    int phase;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    items.valid        <= 1'b0;
    items.opcode       <= OP_TICK;
    items.now_ms       <= '0;
    items.sample_value <= '0;
    hold_token         <= 0;
    no_idle            <= 1'b0;
    events_sent   = 0;
    settings_used = 0;
    clock_ms      = '0;
    level_hi      = SAMPLE_MAX;
    level_lo      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Station still unconfigured: ticks and hits do nothing, unknown opcodes are quiet.
    send_event(OP_TICK, 32'd0, SAMPLE_MAX);
    send_event(OP_SIM_HIT, 32'hFFFF_FFFF, SAMPLE_MAX);
    send_event(OP_SPARE_FIRST, 32'd3, '0);
    send_event(OP_SPARE_LAST, 32'd4, SAMPLE_MAX);
    send_event(OP_PREP_UPD, 32'd5, '0);
    send_event(OP_RECOVER_UPD, 32'd6, '0);
    send_event(OP_HOST_RESET, 32'd7, '0);
    drain();

    // Hysteresis, locking, and locked hits counted even in update mode.
    load_settings(1'b1, 1'b1, 32'd0, 32'd0, 32'd0, 32'hFFFF_F800, 32'h0000_00FF);
    send_event(OP_TICK, 32'd100, 12'h7FF);
    send_event(OP_TICK, 32'd101, SAMPLE_MAX);
    send_event(OP_TICK, 32'd102, 12'h800);
    send_event(OP_TICK, 32'd103, 12'h0FF);
    send_event(OP_TICK, 32'd110, 12'h800);
    send_event(OP_SIM_HIT, 32'd111, '0);
    send_event(OP_PREP_UPD, 32'd112, '0);
    send_event(OP_SIM_HIT, 32'd113, 12'hABC);
    send_event(OP_TICK, 32'd114, SAMPLE_MAX);
    send_event(OP_RECOVER_UPD, 32'd115, '0);
    send_event(OP_HOST_RESET, 32'd116, '0);
    send_event(OP_PREP_UPD, 32'd117, '0);
    send_event(OP_SIM_HIT, 32'd118, 12'h555);
    send_event(OP_RECOVER_UPD, 32'd119, '0);
    send_event(OP_SIM_HIT, 32'd1000, 12'h123);
    drain();

    // Unconfigured while captured: a hit is still counted as locked.
    load_settings(1'b0, 1'b1, 32'd0, 32'd0, 32'd0, 32'hFFFF_F800, 32'h0000_00FF);
    send_event(OP_SIM_HIT, 32'd1002, 12'hF0F);
    drain();

    // Reconfigured while captured; a locked sensor hit followed by the auto reset.
    load_settings(1'b1, 1'b1, 32'd50, 32'd100, 32'd10, 32'h0000_0FFF, 32'h0000_0000);
    send_event(OP_TICK, 32'd1005, '0);
    send_event(OP_TICK, 32'd1060, SAMPLE_MAX);
    send_event(OP_SIM_HIT, 32'd1070, 12'h00F);
    drain();

    // Cooldown blocks a second capture until it has run out; auto reset at the largest time value.
    load_settings(1'b1, 1'b0, 32'd50, 32'd100, 32'd10, 32'h0000_0FFF, 32'h0000_0000);
    send_event(OP_SIM_HIT, 32'd1100, 12'h0F0);
    send_event(OP_SIM_HIT, 32'd1170, 12'hF00);
    send_event(OP_TICK, 32'hFFFF_FFFF, '0);
    drain();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_settings();
      if (phase == 1) begin
        reg_image[REG_CONFIGURED]     = 32'd1;
        reg_image[REG_AUTO_RESET]     = '1;
        reg_image[REG_HIT_COOLDOWN]   = '1;
        reg_image[REG_SAMPLE_IVL]     = '0;
        reg_image[REG_HIT_THRESH]     = '0;
        reg_image[REG_RELEASE_THRESH] = '1;
      end else if (phase == 2) begin
        reg_image[REG_SAMPLE_IVL]     = '1;
        reg_image[REG_HIT_THRESH]     = '1;
        reg_image[REG_RELEASE_THRESH] = '0;
      end
      no_idle <= (phase == 3);
      write_regs();
      random_phase(phase == 4);
      drain();
    end

    $display("summary: %0d events under %0d register settings, %0d result beats checked",
             events_sent, settings_used, beats_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
